// File: rtl/aat_pkg.sv
// ----------------------------------------------------------------------------
// Aging address table package
// Shared widths, codes, state encoding and the control word of the match unit.
// ----------------------------------------------------------------------------
package aat_pkg;

   // Parameter defaults.
   localparam int ENTRIES_DEF  = 64;
   localparam int KEY_BITS_DEF = 64;

   // Fixed field widths of the request and response beats.
   localparam int REQ_TYPE_W = 2;
   localparam int ENTRY_W    = 6;
   localparam int KEY_IN_W   = 64;
   localparam int TIME_W     = 32;
   localparam int COUNT_W    = 7;

   localparam logic [TIME_W-1:0] AGE_LIMIT_RST = 32'd60;

   typedef enum logic [REQ_TYPE_W-1:0] {
      REQ_LOOKUP  = 2'd0,
      REQ_WRITE   = 2'd1,
      REQ_REFRESH = 2'd2,
      REQ_SWEEP   = 2'd3
   } aat_req_type;

   typedef enum logic {
      MAP_GATEWAY = 1'b0,
      MAP_BEACON  = 1'b1
   } aat_map_type;

   typedef enum logic {
      CMP_KEY = 1'b0,
      CMP_AGE = 1'b1
   } aat_cmp_op_type;

   // Control word of the shared match unit.
   typedef struct packed {
      aat_cmp_op_type op;
      aat_map_type    map;
   } aat_cmp_ctl_type;

   typedef enum logic [2:0] {
      ST_CLEAR = 3'd0,
      ST_IDLE  = 3'd1,
      ST_SCAN  = 3'd2,
      ST_STAMP = 3'd3,
      ST_RESP  = 3'd4
   } aat_state_type;

endpackage

// File: rtl/aat_match_unit.sv
// ----------------------------------------------------------------------------
// Aging address table match unit
// Judges one slot per cycle: key equality for searches, age test for sweeps.
// ----------------------------------------------------------------------------
module aat_match_unit #(
   parameter int KEY_BITS = aat_pkg::KEY_BITS_DEF
) (
   input  aat_pkg::aat_cmp_ctl_type          ctl,
   input  logic                              slot_valid,
   input  logic [KEY_BITS-1:0]               net_key,
   input  logic [KEY_BITS-1:0]               uuid_key,
   input  logic [KEY_BITS-1:0]               search_key,
   input  logic [aat_pkg::TIME_W-1:0]        now,
   input  logic [aat_pkg::TIME_W-1:0]        stamp,
   input  logic [aat_pkg::TIME_W-1:0]        limit,
   output logic                              match
);
   import aat_pkg::*;

   logic [KEY_BITS-1:0] key_sel;
   logic [TIME_W-1:0]   age;

   assign key_sel = (ctl.map == MAP_BEACON) ? uuid_key : net_key;
   // The age wraps modulo 2^32, so a plain subtract does it.
   assign age     = now - stamp;

   always_comb begin
      unique case (ctl.op)
         CMP_KEY: begin
            match = slot_valid && (key_sel == search_key);
         end
         CMP_AGE: begin
            match = slot_valid && (age > limit);
         end
         default: begin
            match = 1'b0;
         end
      endcase
   end

endmodule

// File: rtl/aging_address_table.sv
// ----------------------------------------------------------------------------
// Aging address table
// A write goes into the table in its accept cycle and is answered through ST_RESP; req_ready
// is back high from the cycle its response beat appears. A lookup or refresh scans from slot 0
// up and stops at the first hit, and a refresh hit then restamps it in ST_STAMP; a miss or a sweep
// reads every slot, one slot read per cycle. Only one request is in work at a time; reset clears
// the table in a pass during which req_ready stays low, while csr writes are taken as usual.
// ----------------------------------------------------------------------------
module aging_address_table #(
   parameter int ENTRIES  = aat_pkg::ENTRIES_DEF,
   parameter int KEY_BITS = aat_pkg::KEY_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // Request channel.
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [aat_pkg::REQ_TYPE_W-1:0]    req_type,
   input  logic                              req_map_type,
   input  logic [aat_pkg::ENTRY_W-1:0]       req_entry_index,
   input  logic [aat_pkg::KEY_IN_W-1:0]      req_search_key,
   input  logic [aat_pkg::KEY_IN_W-1:0]      req_net_key,
   input  logic [aat_pkg::KEY_IN_W-1:0]      req_uuid_key,
   input  logic [aat_pkg::TIME_W-1:0]        req_current_time,
   // Response channel.
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_hit,
   output logic [aat_pkg::ENTRY_W-1:0]       rsp_match_index,
   output logic [aat_pkg::COUNT_W-1:0]       rsp_released_count,
   // Age limit register.
   input  logic                              csr_write_en,
   input  logic [aat_pkg::TIME_W-1:0]        csr_write_data
);
   import aat_pkg::*;

   localparam int IDX_W = $clog2(ENTRIES);
   localparam int CNT_W = $clog2(ENTRIES + 1);

   // The slot table lives in four memories, each with one write port and one
   // registered read port. All four are read at the same scan address.
   logic                valid_mem [ENTRIES];
   logic [KEY_BITS-1:0] net_mem   [ENTRIES];
   logic [KEY_BITS-1:0] uuid_mem  [ENTRIES];
   logic [TIME_W-1:0]   stamp_mem [ENTRIES];

   // Sequencer state and scan bookkeeping. The issue counter doubles as the
   // address counter of the clearing pass after reset.
   aat_state_type       state_ff, state_in;
   logic [CNT_W-1:0]    issue_ff, issue_in;
   logic                rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]    rd_idx_ff, rd_idx_in;

   // Registered read data of the slot under test.
   logic                rd_valid_ff;
   logic [KEY_BITS-1:0] rd_net_ff;
   logic [KEY_BITS-1:0] rd_uuid_ff;
   logic [TIME_W-1:0]   rd_stamp_ff;

   // The request held for the length of its scan.
   aat_req_type         kind_ff, kind_in;
   aat_map_type         map_ff, map_in;
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [TIME_W-1:0]   now_ff, now_in;

   // Result being built, and the output register that holds a finished beat.
   logic                res_hit_ff, res_hit_in;
   logic [IDX_W-1:0]    res_idx_ff, res_idx_in;
   logic [CNT_W-1:0]    res_cnt_ff, res_cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_hit_ff, rsp_hit_in;
   logic [ENTRY_W-1:0]  rsp_idx_ff, rsp_idx_in;
   logic [COUNT_W-1:0]  rsp_cnt_ff, rsp_cnt_in;

   logic [TIME_W-1:0]   age_limit_ff;

   // Memory port controls.
   logic                rd_en;
   logic [IDX_W-1:0]    rd_addr;
   logic [IDX_W-1:0]    wr_addr;
   logic                valid_we, net_we, uuid_we, stamp_we;
   logic                valid_wdata;
   logic [KEY_BITS-1:0] net_wdata, uuid_wdata;
   logic [TIME_W-1:0]   stamp_wdata;

   // Shared match unit and scan status.
   aat_cmp_ctl_type     cmp_ctl;
   logic                cmp_match;
   logic                accept;
   logic                issuing;
   logic                found;
   logic                scan_last;
   logic                wr_in_range;
   logic                resp_load;

   assign accept      = req_valid && req_ready;
   assign req_ready   = (state_ff == ST_IDLE);
   assign rd_addr     = issue_ff[IDX_W-1:0];
   // A write aimed beyond the table leaves it untouched.
   assign wr_in_range = (32'(req_entry_index) < ENTRIES);

   // The scan issues one read per cycle until every slot has been read or a search has hit; the
   // slot read in the previous cycle is judged in the current one.
   assign issuing   = (issue_ff != CNT_W'(ENTRIES));
   assign scan_last = !issuing && rd_vld_ff;
   assign found     = rd_vld_ff && cmp_match && (kind_ff != REQ_SWEEP);
   assign resp_load = !rsp_valid_ff || rsp_ready;

   assign cmp_ctl.op  = (kind_ff == REQ_SWEEP) ? CMP_AGE : CMP_KEY;
   assign cmp_ctl.map = map_ff;

   aat_match_unit #(
      .KEY_BITS (KEY_BITS)
   ) u_match (
      .ctl        (cmp_ctl),
      .slot_valid (rd_valid_ff),
      .net_key    (rd_net_ff),
      .uuid_key   (rd_uuid_ff),
      .search_key (key_ff),
      .now        (now_ff),
      .stamp      (rd_stamp_ff),
      .limit      (age_limit_ff),
      .match      (cmp_match)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (issue_ff == CNT_W'(ENTRIES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (aat_req_type'(req_type) == REQ_WRITE) begin
                  state_in = ST_RESP;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            // A search stops at the lowest matching slot; a sweep runs to the end.
            if (found) begin
               state_in = (kind_ff == REQ_REFRESH) ? ST_STAMP : ST_RESP;
            end else if (scan_last) begin
               state_in = ST_RESP;
            end
         end
         ST_STAMP: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (resp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // Datapath and memory controls.
   always_comb begin
      issue_in     = issue_ff;
      rd_vld_in    = 1'b0;
      rd_idx_in    = rd_addr;
      rd_en        = 1'b0;
      wr_addr      = rd_addr;
      valid_we     = 1'b0;
      net_we       = 1'b0;
      uuid_we      = 1'b0;
      stamp_we     = 1'b0;
      valid_wdata  = 1'b0;
      net_wdata    = '0;
      uuid_wdata   = '0;
      stamp_wdata  = req_current_time;
      kind_in      = kind_ff;
      map_in       = map_ff;
      key_in       = key_ff;
      now_in       = now_ff;
      res_hit_in   = res_hit_ff;
      res_idx_in   = res_idx_ff;
      res_cnt_in   = res_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_hit_in   = rsp_hit_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_cnt_in   = rsp_cnt_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            // Valid flags and both keys are cleared one slot per cycle.
            valid_we = 1'b1;
            net_we   = 1'b1;
            uuid_we  = 1'b1;
            issue_in = issue_ff + CNT_W'(1);
         end
         ST_IDLE: begin
            if (accept) begin
               kind_in    = aat_req_type'(req_type);
               map_in     = aat_map_type'(req_map_type);
               key_in     = req_search_key[KEY_BITS-1:0];
               now_in     = req_current_time;
               res_hit_in = 1'b0;
               res_idx_in = '0;
               res_cnt_in = '0;
               issue_in   = '0;
               unique case (aat_req_type'(req_type)) inside
                  REQ_WRITE: begin
                     // A write goes straight into the table in the accept cycle.
                     wr_addr     = IDX_W'(req_entry_index);
                     valid_wdata = 1'b1;
                     net_wdata   = req_net_key[KEY_BITS-1:0];
                     uuid_wdata  = req_uuid_key[KEY_BITS-1:0];
                     valid_we    = wr_in_range;
                     net_we      = wr_in_range;
                     stamp_we    = wr_in_range;
                     // A gateway write keeps the slot's identifier key.
                     uuid_we     = wr_in_range &&
                                   (aat_map_type'(req_map_type) == MAP_BEACON);
                  end
                  REQ_LOOKUP, REQ_REFRESH, REQ_SWEEP: begin
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (issuing && !found) begin
               rd_en     = 1'b1;
               rd_vld_in = 1'b1;
               issue_in  = issue_ff + CNT_W'(1);
            end
            if (found) begin
               res_hit_in = 1'b1;
               res_idx_in = rd_idx_ff;
            end
            // A sweep releases an aged slot in the cycle it is judged.
            if ((kind_ff == REQ_SWEEP) && rd_vld_ff && cmp_match) begin
               wr_addr     = rd_idx_ff;
               valid_we    = 1'b1;
               valid_wdata = 1'b0;
               res_cnt_in  = res_cnt_ff + CNT_W'(1);
            end
         end
         ST_STAMP: begin
            wr_addr     = res_idx_ff;
            stamp_we    = 1'b1;
            stamp_wdata = now_ff;
         end
         ST_RESP: begin
            if (resp_load) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in   = res_hit_ff;
               rsp_idx_in   = ENTRY_W'(res_idx_ff);
               rsp_cnt_in   = COUNT_W'(res_cnt_ff);
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         issue_ff     <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issue_ff     <= issue_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         age_limit_ff <= AGE_LIMIT_RST;
      end else if (csr_write_en) begin
         age_limit_ff <= csr_write_data;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      rd_idx_ff  <= rd_idx_in;
      kind_ff    <= kind_in;
      map_ff     <= map_in;
      key_ff     <= key_in;
      now_ff     <= now_in;
      res_hit_ff <= res_hit_in;
      res_idx_ff <= res_idx_in;
      res_cnt_ff <= res_cnt_in;
      rsp_hit_ff <= rsp_hit_in;
      rsp_idx_ff <= rsp_idx_in;
      rsp_cnt_ff <= rsp_cnt_in;
   end

   // Table memories.
   always_ff @(posedge clock) begin
      if (valid_we) begin
         valid_mem[wr_addr] <= valid_wdata;
      end
      if (net_we) begin
         net_mem[wr_addr] <= net_wdata;
      end
      if (uuid_we) begin
         uuid_mem[wr_addr] <= uuid_wdata;
      end
      if (stamp_we) begin
         stamp_mem[wr_addr] <= stamp_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_valid_ff <= valid_mem[rd_addr];
         rd_net_ff   <= net_mem[rd_addr];
         rd_uuid_ff  <= uuid_mem[rd_addr];
         rd_stamp_ff <= stamp_mem[rd_addr];
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_hit            = rsp_hit_ff;
   assign rsp_match_index    = rsp_idx_ff;
   assign rsp_released_count = rsp_cnt_ff;

   // No response beat may come out of the clearing pass.
   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !rsp_valid_ff)
      else $error("response beat during the clearing pass");

   // A sweep cannot release more slots than it has read.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (res_cnt_ff <= issue_ff))
      else $error("release count ahead of the scan");

   // Read data is judged only in the cycle after a scan read.
   a_read_source: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> ($past(state_ff) == ST_SCAN))
      else $error("slot judged without a scan read");

   // A hit and a release count never share one beat.
   a_hit_no_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_hit_ff) |-> (rsp_cnt_ff == '0))
      else $error("hit beat carries a release count");

endmodule

// File: test/aat_checker.sv
// ----------------------------------------------------------------------------
// Aging address table checker
// Watches the request, response and csr ports, keeps its own copy of the
// table and compares every response beat with the oldest predicted answer.
// ----------------------------------------------------------------------------
module aat_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  logic [aat_pkg::REQ_TYPE_W-1:0] req_type,
   input  logic                           req_map_type,
   input  logic [aat_pkg::ENTRY_W-1:0]    req_entry_index,
   input  logic [aat_pkg::KEY_IN_W-1:0]   req_search_key,
   input  logic [aat_pkg::KEY_IN_W-1:0]   req_net_key,
   input  logic [aat_pkg::KEY_IN_W-1:0]   req_uuid_key,
   input  logic [aat_pkg::TIME_W-1:0]     req_current_time,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  logic                           rsp_hit,
   input  logic [aat_pkg::ENTRY_W-1:0]    rsp_match_index,
   input  logic [aat_pkg::COUNT_W-1:0]    rsp_released_count,
   input  logic                           csr_write_en,
   input  logic [aat_pkg::TIME_W-1:0]     csr_write_data,
   output int unsigned                    fail_count,
   output int unsigned                    pending_count
);
   import aat_pkg::*;

   localparam int ENTRIES = ENTRIES_DEF;

   typedef struct packed {
      logic               hit;
      logic [ENTRY_W-1:0] index;
      logic [COUNT_W-1:0] released;
   } table_answer_type;

   logic                slot_live  [ENTRIES];
   logic [KEY_IN_W-1:0] slot_net   [ENTRIES];
   logic [KEY_IN_W-1:0] slot_uuid  [ENTRIES];
   logic [TIME_W-1:0]   slot_stamp [ENTRIES];
   logic [TIME_W-1:0]   limit_shadow;
   table_answer_type    answers_due [$];

   initial begin
      fail_count    = 0;
      pending_count = 0;
   end

   // Applies one request to the shadow table and returns the answer it must produce.
   function automatic table_answer_type apply_request(
      input aat_req_type       kind,
      input aat_map_type       map,
      input logic [ENTRY_W-1:0] slot,
      input logic [KEY_IN_W-1:0] skey,
      input logic [KEY_IN_W-1:0] nkey,
      input logic [KEY_IN_W-1:0] ukey,
      input logic [TIME_W-1:0]  now
   );
      table_answer_type  ans;
      int                found;
      int                released;
      logic [TIME_W-1:0] age;
      ans      = '0;
      found    = -1;
      released = 0;
      case (kind) inside
         REQ_LOOKUP, REQ_REFRESH: begin
            // Walk downward so the lowest matching slot is the one left in found.
            for (int n = ENTRIES - 1; n >= 0; n--) begin
               if (slot_live[n] && ((map == MAP_GATEWAY) ? slot_net[n] : slot_uuid[n]) == skey)
                  found = n;
            end
            if (found >= 0) begin
               ans.hit   = 1'b1;
               ans.index = found[ENTRY_W-1:0];
               if (kind == REQ_REFRESH)
                  slot_stamp[found] = now;
            end
         end
         REQ_WRITE: begin
            // A six-bit index always lands inside a 64-slot table.
            slot_live[slot]  = 1'b1;
            slot_stamp[slot] = now;
            slot_net[slot]   = nkey;
            if (map == MAP_BEACON)
               slot_uuid[slot] = ukey;
         end
         default: begin
            for (int n = 0; n < ENTRIES; n++) begin
               age = now - slot_stamp[n];
               if (slot_live[n] && age > limit_shadow) begin
                  slot_live[n] = 1'b0;
                  released++;
               end
            end
            ans.released = released[COUNT_W-1:0];
         end
      endcase
      return ans;
   endfunction

   always @(posedge clock) begin
      table_answer_type want;
      if (reset) begin
         for (int n = 0; n < ENTRIES; n++) begin
            slot_live[n] = 1'b0;
            slot_net[n]  = '0;
            slot_uuid[n] = '0;
         end
         limit_shadow = AGE_LIMIT_RST;
         answers_due.delete();
      end else begin
         if (csr_write_en)
            limit_shadow = csr_write_data;
         // Predict before checking, so a same-edge answer still finds its entry.
         if (req_valid && req_ready)
            answers_due.push_back(apply_request(aat_req_type'(req_type),
               aat_map_type'(req_map_type), req_entry_index, req_search_key,
               req_net_key, req_uuid_key, req_current_time));
         if (rsp_valid && rsp_ready) begin
            if (answers_due.size() == 0) begin
               if (fail_count < 10)
                  $display("chk: unexpected response beat hit=%0b index=%0d released=%0d",
                           rsp_hit, rsp_match_index, rsp_released_count);
               fail_count++;
            end else begin
               want = answers_due.pop_front();
               if (want.hit !== rsp_hit || want.index !== rsp_match_index ||
                   want.released !== rsp_released_count) begin
                  if (fail_count < 10) begin
                     $write("chk: mismatch, expected hit=%0b index=%0d released=%0d,",
                            want.hit, want.index, want.released);
                     $display(" got hit=%0b index=%0d released=%0d",
                              rsp_hit, rsp_match_index, rsp_released_count);
                  end
                  fail_count++;
               end
            end
         end
      end
      pending_count = answers_due.size();
   end

endmodule

// File: test/tb.sv
// ----------------------------------------------------------------------------
// Aging address table testbench
// Drives directed and random lookup, write, refresh and sweep beats through
// the table under several age limits, with random idling on both channels;
// a separate checker predicts and compares every response beat.
// ----------------------------------------------------------------------------
module tb;
   import aat_pkg::*;

   // A miss or sweep reads every slot, so that bounds the settle time.
   localparam int          SETTLE_CYCLES = ENTRIES_DEF + 8;
   // This leaves a wide margin over the slowest correct run.
   localparam int unsigned CYCLE_LIMIT   = 1000000;
   localparam int unsigned HOLD_CYCLES   = 400;
   localparam int unsigned PHASE_BEATS   = 110;
   localparam int          POOL_SIZE     = 12;
   localparam logic [KEY_IN_W-1:0] ONES  = '1;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [REQ_TYPE_W-1:0] req_type;
   logic                  req_map_type;
   logic [ENTRY_W-1:0]    req_entry_index;
   logic [KEY_IN_W-1:0]   req_search_key;
   logic [KEY_IN_W-1:0]   req_net_key;
   logic [KEY_IN_W-1:0]   req_uuid_key;
   logic [TIME_W-1:0]     req_current_time;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic                  rsp_hit;
   logic [ENTRY_W-1:0]    rsp_match_index;
   logic [COUNT_W-1:0]    rsp_released_count;
   logic                  csr_write_en;
   logic [TIME_W-1:0]     csr_write_data;

   int unsigned fail_count;
   int unsigned pending_count;
   int unsigned cycle_count = 0;

   // Per-phase idling switches and the one-shot request for a long receiver hold.
   bit req_steady;
   bit rsp_steady;
   bit hold_pending;

   // Shared key pool so that lookups and refreshes hit often, and a running clock.
   logic [KEY_IN_W-1:0] key_pool [POOL_SIZE];
   logic [TIME_W-1:0]   wall_time;

   aging_address_table dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_type           (req_type),
      .req_map_type       (req_map_type),
      .req_entry_index    (req_entry_index),
      .req_search_key     (req_search_key),
      .req_net_key        (req_net_key),
      .req_uuid_key       (req_uuid_key),
      .req_current_time   (req_current_time),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_hit            (rsp_hit),
      .rsp_match_index    (rsp_match_index),
      .rsp_released_count (rsp_released_count),
      .csr_write_en       (csr_write_en),
      .csr_write_data     (csr_write_data)
   );

   aat_checker chk (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_type           (req_type),
      .req_map_type       (req_map_type),
      .req_entry_index    (req_entry_index),
      .req_search_key     (req_search_key),
      .req_net_key        (req_net_key),
      .req_uuid_key       (req_uuid_key),
      .req_current_time   (req_current_time),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_hit            (rsp_hit),
      .rsp_match_index    (rsp_match_index),
      .rsp_released_count (rsp_released_count),
      .csr_write_en       (csr_write_en),
      .csr_write_data     (csr_write_data),
      .fail_count         (fail_count),
      .pending_count      (pending_count)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: done, errors");
         $finish;
      end
   end

   // Gap lengths: mostly back to back, often a short gap, rarely a long pause.
   function automatic int unsigned pick_gap(input bit steady);
      int unsigned roll;
      if (steady)
         return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55)
         return 0;
      if (roll < 85)
         return $urandom_range(1, 3);
      if (roll < 97)
         return $urandom_range(4, 12);
      return $urandom_range(30, 90);
   endfunction

   function automatic logic [KEY_IN_W-1:0] pick_key();
      if ($urandom_range(0, 99) < 88)
         return key_pool[$urandom_range(0, POOL_SIZE - 1)];
      return {$urandom, $urandom};
   endfunction

   // Receiver side. It takes beats with random stalls, and when asked it holds
   // rsp_ready low for a long stretch so the table backs up and stops taking
   // requests while the sender keeps offering.
   initial begin
      int unsigned stall_left;
      stall_left = 0;
      rsp_ready  = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_pending) begin
            hold_pending = 1'b0;
            stall_left   = HOLD_CYCLES;
         end
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready  <= 1'b1;
            stall_left = pick_gap(rsp_steady);
         end
      end
   end

   // Offers one request beat and holds it until accepted. Starts and ends at a
   // falling edge; valid is only dropped when a gap follows, so back-to-back
   // beats never see valid lowered and raised in the same step.
   task automatic offer_request(
      input aat_req_type         kind,
      input aat_map_type         map,
      input logic [ENTRY_W-1:0]  slot,
      input logic [KEY_IN_W-1:0] skey,
      input logic [KEY_IN_W-1:0] nkey,
      input logic [KEY_IN_W-1:0] ukey,
      input logic [TIME_W-1:0]   now
   );
      int unsigned gap;
      req_valid        <= 1'b1;
      req_type         <= kind;
      req_map_type     <= map;
      req_entry_index  <= slot;
      req_search_key   <= skey;
      req_net_key      <= nkey;
      req_uuid_key     <= ukey;
      req_current_time <= now;
      do
         @(posedge clock);
      while (req_ready !== 1'b1);
      @(negedge clock);
      gap = pick_gap(req_steady);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // Waits until every predicted answer has come back, then lets the longest
   // scan finish so the table is truly idle.
   task automatic drain_table();
      req_valid <= 1'b0;
      while (pending_count != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_age_limit(input logic [TIME_W-1:0] value);
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_en   <= 1'b0;
   endtask

   // Directed part, run with the reset age limit of 60 seconds.
   task automatic run_directed();
      localparam logic [KEY_IN_W-1:0] KEY_A = 64'h0123_4567_89AB_CDEF;
      localparam logic [KEY_IN_W-1:0] KEY_B = 64'hFEDC_BA98_7654_3210;
      localparam logic [KEY_IN_W-1:0] KEY_U = 64'h5A5A_A5A5_0F0F_F0F0;
      localparam logic [KEY_IN_W-1:0] KEY_C = 64'h8000_0000_0000_0001;
      // An empty table misses even on the all-zero key held by cleared slots.
      offer_request(REQ_LOOKUP, MAP_GATEWAY, 6'd0, '0, '0, '0, 32'd1000);
      offer_request(REQ_LOOKUP, MAP_BEACON, 6'd63, '0, '0, '0, 32'd1000);
      // Extreme keys in the first and last slots.
      offer_request(REQ_WRITE, MAP_GATEWAY, 6'd0, '0, ONES, '0, 32'd1000);
      offer_request(REQ_WRITE, MAP_BEACON, 6'd63, '0, KEY_A, ONES, 32'd1000);
      offer_request(REQ_LOOKUP, MAP_GATEWAY, 6'd17, ONES, '0, '0, 32'd1000);
      offer_request(REQ_LOOKUP, MAP_BEACON, 6'd17, ONES, '0, '0, 32'd1000);
      // A gateway write over a beacon slot keeps the old identifier key.
      offer_request(REQ_WRITE, MAP_BEACON, 6'd5, '0, KEY_A, KEY_U, 32'd1000);
      offer_request(REQ_WRITE, MAP_GATEWAY, 6'd5, '0, KEY_B, ONES, 32'd1010);
      offer_request(REQ_LOOKUP, MAP_BEACON, 6'd0, KEY_U, '0, '0, 32'd1010);
      offer_request(REQ_LOOKUP, MAP_GATEWAY, 6'd0, KEY_A, '0, '0, 32'd1010);
      // Two slots with the same key: the lower one wins.
      offer_request(REQ_WRITE, MAP_GATEWAY, 6'd9, '0, ONES, '0, 32'd1020);
      offer_request(REQ_LOOKUP, MAP_GATEWAY, 6'd0, ONES, '0, '0, 32'd1020);
      // A stored zero key is a real match once the slot is valid.
      offer_request(REQ_WRITE, MAP_BEACON, 6'd2, '0, '0, '0, 32'd1000);
      offer_request(REQ_LOOKUP, MAP_GATEWAY, 6'd0, '0, '0, '0, 32'd1000);
      // Refresh hit restamps slot 0; a refresh miss changes nothing.
      offer_request(REQ_REFRESH, MAP_GATEWAY, 6'd0, ONES, '0, '0, 32'd1061);
      offer_request(REQ_REFRESH, MAP_BEACON, 6'd0, KEY_C, '0, '0, 32'd1061);
      // Age exactly at the limit stays, one second past it is released.
      offer_request(REQ_SWEEP, MAP_GATEWAY, 6'd0, '0, '0, '0, 32'd1070);
      offer_request(REQ_SWEEP, MAP_GATEWAY, 6'd0, '0, '0, '0, 32'd1071);
      offer_request(REQ_LOOKUP, MAP_BEACON, 6'd0, KEY_U, '0, '0, 32'd1071);
      // The age difference wraps around the top of the 32-bit clock.
      offer_request(REQ_WRITE, MAP_GATEWAY, 6'd40, '0, KEY_C, '0, 32'hFFFF_FFF0);
      offer_request(REQ_SWEEP, MAP_BEACON, 6'd0, '0, '0, '0, 32'h0000_0020);
      offer_request(REQ_SWEEP, MAP_BEACON, 6'd0, '0, '0, '0, 32'h0000_002D);
      offer_request(REQ_LOOKUP, MAP_GATEWAY, 6'd0, KEY_C, '0, '0, 32'h0000_002D);
      // A beacon refresh keeps its slot through a later sweep.
      offer_request(REQ_WRITE, MAP_BEACON, 6'd1, '0, '0, ONES, 32'd100);
      offer_request(REQ_REFRESH, MAP_BEACON, 6'd0, ONES, '0, '0, 32'd200);
      offer_request(REQ_SWEEP, MAP_GATEWAY, 6'd0, '0, '0, '0, 32'd250);
   endtask

   // Random part: mostly writes, lookups and refreshes drawn from the key pool
   // on a clock that creeps forward, with sweeps and the odd large time jump.
   task automatic run_random(input int unsigned beats);
      int unsigned         roll;
      aat_req_type         kind;
      logic [ENTRY_W-1:0]  slot;
      for (int unsigned i = 0; i < beats; i++) begin
         roll = $urandom_range(0, 99);
         if (roll < 35)
            kind = REQ_WRITE;
         else if (roll < 60)
            kind = REQ_LOOKUP;
         else if (roll < 85)
            kind = REQ_REFRESH;
         else
            kind = REQ_SWEEP;
         roll = $urandom_range(0, 99);
         if (roll < 50)
            slot = ENTRY_W'($urandom_range(0, 7));
         else if (roll < 80)
            slot = ENTRY_W'($urandom_range(0, 63));
         else
            slot = ENTRY_W'($urandom_range(56, 63));
         roll = $urandom_range(0, 99);
         if (roll < 70)
            wall_time = wall_time + $urandom_range(0, 20);
         else if (roll < 92)
            wall_time = wall_time + $urandom_range(0, 120);
         else
            wall_time = $urandom;
         offer_request(kind, aat_map_type'($urandom_range(0, 1)), slot,
                       pick_key(), pick_key(), pick_key(), wall_time);
      end
   endtask

   initial begin
      logic [TIME_W-1:0] limit_now;
      // Every input is known from time zero, while reset is held.
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_type         = REQ_LOOKUP;
      req_map_type     = MAP_GATEWAY;
      req_entry_index  = '0;
      req_search_key   = '0;
      req_net_key      = '0;
      req_uuid_key     = '0;
      req_current_time = '0;
      csr_write_en     = 1'b0;
      csr_write_data   = '0;
      req_steady       = 1'b0;
      rsp_steady       = 1'b0;
      hold_pending     = 1'b0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      // The clearing pass after reset keeps req_ready low; offer_request waits it out.
      run_directed();
      drain_table();
      // Each phase sets a new age limit while idle, refills the key pool and
      // picks its own idling style; two phases also start with a long hold.
      for (int p = 0; p < 5; p++) begin
         case (p)
            0:       limit_now = '0;
            1:       limit_now = $urandom_range(1, 100);
            2:       limit_now = '1;
            3:       limit_now = $urandom;
            default: limit_now = 32'd1;
         endcase
         write_age_limit(limit_now);
         for (int k = 0; k < POOL_SIZE; k++)
            key_pool[k] = {$urandom, $urandom};
         wall_time    = (p == 2) ? 32'hFFFF_FF00 : $urandom;
         req_steady   = (p == 3);
         rsp_steady   = (p == 4);
         hold_pending = (p == 1 || p == 3);
         run_random(PHASE_BEATS);
         drain_table();
      end
      if (fail_count == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end

endmodule

// File: files.f
rtl/aat_pkg.sv
rtl/aat_match_unit.sv
rtl/aging_address_table.sv
test/aat_checker.sv
test/tb.sv
